// File: hdl/rbuf_pkg.sv
// Package: shared types and constants of the rollback union-find block.
`default_nettype none
package rbuf_pkg;

  localparam int NODE_W = 10;   // node index and stack depth fields
  localparam int CNT_W  = 11;   // node count and component count fields

  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  localparam logic MODE_UNITE    = 1'b0;
  localparam logic MODE_ROLLBACK = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_LINK,
    ST_LINK2,
    ST_POP_RD,
    ST_POP_C,
    ST_POP_R,
    ST_POP_W1,
    ST_POP_W2,
    ST_FINISH
  } rbuf_state_t;

endpackage
`default_nettype wire

// File: hdl/rbuf_ifs.sv
// Interfaces: request, response and configuration channels.
`default_nettype none
interface rbuf_req_if import rbuf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic [NODE_W-1:0] rollback_target;

  modport source (output valid, mode, node_a, node_b, rollback_target, input ready);
  modport sink   (input valid, mode, node_a, node_b, rollback_target, output ready);
endinterface

interface rbuf_rsp_if import rbuf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              merged;
  logic [CNT_W-1:0]  component_count;
  logic [NODE_W-1:0] stack_depth;
  logic              bad_node;

  modport source (output valid, merged, component_count, stack_depth, bad_node,
                  input ready);
  modport sink   (input valid, merged, component_count, stack_depth, bad_node,
                  output ready);
endinterface

interface rbuf_cfg_if import rbuf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: hdl/rbuf_ram.sv
// Simple dual-port synchronous RAM, one write port, one registered read port.
`default_nettype none
module rbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/rollback_union_find_top.sv
// Top level: union-find with rollback, sequencer around node and undo memories.
//
//  channel | dir | handshake    | word
//  --------+-----+--------------+------------------------------------------------
//  req     | in  | valid/ready  | mode, node_a, node_b, rollback_target
//  rsp     | out | valid/ready  | merged, component_count, stack_depth, bad_node
//  cfg     | in  | valid/ready  | data = node_count (always ready)
//
//  Unite: after the accept, each root walk visits one node per cycle
//  (root depth + 1 nodes per walk, at most log2(NODES)+1 each), then a link
//  step plus a second one when the sets merge, and the result state; the walk
//  rate is set by the one read port of the node memory. A flagged unite goes
//  from the accept straight to the result state. Rollback: each popped entry
//  takes a stack read, two node reads and two node writes through the single
//  node write port. After reset and after every node_count write the node
//  memory is swept, one entry a cycle; req.ready stays low meanwhile.
//  A new request is taken while a result still waits in the output register;
//  its result then waits in the result state until rsp drains.
`default_nettype none
module rollback_union_find_top import rbuf_pkg::*; #(
  parameter int NODES = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rbuf_req_if.sink   req,
  rbuf_rsp_if.source rsp,
  rbuf_cfg_if.sink   cfg
);

  localparam int IW = $clog2(NODES);          // node index
  localparam int SW = $clog2(NODES + 1);      // tree size, set count, depth
  localparam int CW = (SW > CNT_W) ? SW : CNT_W;
  localparam int NW = IW + SW;                // node word: {parent, size}
  localparam logic [CW-1:0] NODES_CW = CW'(NODES);

  rbuf_state_t state, state_next;

  // control and bookkeeping
  logic [SW-1:0] active;        // node_count limited to NODES
  logic [SW-1:0] set_count;
  logic [SW-1:0] depth;
  logic [IW-1:0] clr_idx;

  // per-request working registers
  logic [IW-1:0] cur;
  logic [IW-1:0] b_idx;
  logic [IW-1:0] ra, rb;
  logic [SW-1:0] sa, sb;
  logic [IW-1:0] c_reg, r_reg;
  logic [SW-1:0] sc_reg, sum_reg;
  logic          merged_r, bad_r;

  // memory ports
  logic          node_we;
  logic [IW-1:0] node_waddr, node_raddr;
  logic [NW-1:0] node_wdata, node_q;
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_raddr;
  logic [2*IW-1:0] stk_wdata, stk_q;

  rbuf_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_mem (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_q)
  );

  rbuf_ram #(.WIDTH(2 * IW), .DEPTH(NODES)) u_undo_mem (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  // node word fields as read back
  logic [IW-1:0] nq_par;
  logic [SW-1:0] nq_size;
  assign nq_par  = node_q[NW-1:SW];
  assign nq_size = node_q[SW-1:0];

  logic [IW-1:0] stk_child, stk_root;
  assign stk_child = stk_q[2*IW-1:IW];
  assign stk_root  = stk_q[IW-1:0];

  // request decode
  logic                 req_acc, cfg_acc;
  logic [IW+NODE_W-1:0] a_ext, b_ext;
  logic [IW-1:0]        a_idx, b_idx_in;
  logic                 bad_in, pop_more_in, pop_more;
  logic [CW-1:0]        cfg_cw, cfg_lim, rst_cw, rst_lim, target_cw;
  logic [NODE_W-1:0]    target;

  assign req_acc  = req.valid && req.ready;
  assign cfg_acc  = cfg.valid && cfg.ready;
  assign a_ext    = {{IW{1'b0}}, req.node_a};
  assign b_ext    = {{IW{1'b0}}, req.node_b};
  assign a_idx    = a_ext[IW-1:0];
  assign b_idx_in = b_ext[IW-1:0];
  assign bad_in   = (CW'(req.node_a) >= CW'(active)) || (CW'(req.node_b) >= CW'(active));
  assign pop_more_in = CW'(depth) > CW'(req.rollback_target);
  // after the pop in flight, depth is already decremented
  assign target_cw = CW'(target);
  assign pop_more  = CW'(depth) > target_cw;

  assign cfg_cw  = CW'(cfg.data);
  assign cfg_lim = (cfg_cw > NODES_CW) ? NODES_CW : cfg_cw;
  assign rst_cw  = CW'(NODE_COUNT_RESET);
  assign rst_lim = (rst_cw > NODES_CW) ? NODES_CW : rst_cw;

  // link decision: the smaller tree goes under the larger, first root on ties
  logic          swap, do_merge;
  logic [IW-1:0] link_c, link_r;
  logic [SW-1:0] link_sc, link_sr;
  assign swap     = sa < sb;
  assign do_merge = (ra != rb) && (depth != SW'(NODES));
  assign link_c   = swap ? ra : rb;
  assign link_r   = swap ? rb : ra;
  assign link_sc  = swap ? sa : sb;
  assign link_sr  = swap ? sb : sa;

  logic out_free;
  assign out_free = !rsp.valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_idx == IW'(NODES - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (req_acc) begin
          if (req.mode == MODE_UNITE) begin
            state_next = bad_in ? ST_FINISH : ST_WALK_A;
          end else begin
            state_next = pop_more_in ? ST_POP_RD : ST_FINISH;
          end
        end
      end
      ST_WALK_A: if (nq_par == cur) state_next = ST_WALK_B;
      ST_WALK_B: if (nq_par == cur) state_next = ST_LINK;
      ST_LINK:   state_next = do_merge ? ST_LINK2 : ST_FINISH;
      ST_LINK2:  state_next = ST_FINISH;
      ST_POP_RD: state_next = ST_POP_C;
      ST_POP_C:  state_next = ST_POP_R;
      ST_POP_R:  state_next = ST_POP_W1;
      ST_POP_W1: state_next = ST_POP_W2;
      ST_POP_W2: state_next = pop_more ? ST_POP_RD : ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
    if (cfg_acc) state_next = ST_CLEAR;
  end

  // memory controls
  always_comb begin
    node_we    = 1'b0;
    node_waddr = clr_idx;
    node_wdata = {clr_idx, SW'(1)};
    node_raddr = cur;
    stk_we     = 1'b0;
    case (state)
      ST_CLEAR: node_we = 1'b1;
      ST_IDLE:  node_raddr = a_idx;
      ST_WALK_A: node_raddr = (nq_par == cur) ? b_idx : nq_par;
      ST_WALK_B: node_raddr = nq_par;
      ST_LINK: begin
        node_we    = do_merge;
        node_waddr = link_c;
        node_wdata = {link_r, link_sc};
        stk_we     = do_merge;
      end
      ST_LINK2: begin
        node_we    = 1'b1;
        node_waddr = r_reg;
        node_wdata = {r_reg, sum_reg};
      end
      ST_POP_C: node_raddr = stk_child;
      ST_POP_R: node_raddr = r_reg;
      ST_POP_W1: begin
        node_we    = 1'b1;
        node_waddr = r_reg;
        node_wdata = {nq_par, nq_size - sc_reg};
      end
      ST_POP_W2: begin
        node_we    = 1'b1;
        node_waddr = c_reg;
        node_wdata = {c_reg, sc_reg};
      end
      default: ;
    endcase
  end

  // stack pointer addressing: push at depth, pop reads depth-1
  logic [SW-1:0] depth_m1;
  assign depth_m1  = depth - SW'(1);
  assign stk_waddr = depth[IW-1:0];
  assign stk_wdata = {link_c, link_r};
  assign stk_raddr = depth_m1[IW-1:0];

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      active    <= rst_lim[SW-1:0];
      set_count <= rst_lim[SW-1:0];
      depth     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR && !cfg_acc) clr_idx <= clr_idx + IW'(1);
      if (state == ST_LINK && do_merge) begin
        depth     <= depth + SW'(1);
        set_count <= set_count - SW'(1);
      end
      if (state == ST_POP_RD) depth <= depth_m1;
      if (state == ST_POP_W2) set_count <= set_count + SW'(1);
      if (state == ST_FINISH && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (cfg_acc) begin
        clr_idx   <= '0;
        active    <= cfg_lim[SW-1:0];
        set_count <= cfg_lim[SW-1:0];
        depth     <= '0;
      end
    end
  end

  // working registers and result word
  logic [CW-1:0] set_cw, depth_cw;
  assign set_cw   = CW'(set_count);
  assign depth_cw = CW'(depth);

  always_ff @(posedge clk) begin
    if (req_acc) begin
      cur      <= a_idx;
      b_idx    <= b_idx_in;
      target   <= req.rollback_target;
      merged_r <= 1'b0;
      bad_r    <= (req.mode == MODE_UNITE) && bad_in;
    end
    case (state)
      ST_WALK_A: begin
        if (nq_par == cur) begin
          ra  <= cur;
          sa  <= nq_size;
          cur <= b_idx;
        end else begin
          cur <= nq_par;
        end
      end
      ST_WALK_B: begin
        if (nq_par == cur) begin
          rb <= cur;
          sb <= nq_size;
        end else begin
          cur <= nq_par;
        end
      end
      ST_LINK: begin
        r_reg    <= link_r;
        sum_reg  <= link_sr + link_sc;
        merged_r <= do_merge;
      end
      ST_POP_C: begin
        c_reg <= stk_child;
        r_reg <= stk_root;
      end
      ST_POP_R: sc_reg <= nq_size;
      default: ;
    endcase
    if (state == ST_FINISH && out_free) begin
      rsp.merged          <= merged_r;
      rsp.bad_node        <= bad_r;
      rsp.component_count <= set_cw[CNT_W-1:0];
      rsp.stack_depth     <= depth_cw[NODE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: hdl/rbuf_checker.sv
// Checker: port-level assertions for the rollback union-find top, with bind.
`default_nettype none
module rbuf_checker import rbuf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic              rsp_merged,
  input wire logic              rsp_bad_node,
  input wire logic [CNT_W-1:0]  rsp_count,
  input wire logic [NODE_W-1:0] rsp_depth,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready
);

  // a count write starts the memory sweep, no request right after it
  a_cfg_sweep: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !req_ready)
    else $error("request taken right after a count write");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while one is in flight");

  // a merge is never reported for a flagged request
  a_merge_not_bad: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_merged && rsp_bad_node))
    else $error("merged and bad_node both set");

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_merged)
      && $stable(rsp_bad_node) && $stable(rsp_count) && $stable(rsp_depth))
    else $error("stalled result word changed");

endmodule

bind rollback_union_find_top rbuf_checker u_rbuf_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_merged   (rsp.merged),
  .rsp_bad_node (rsp.bad_node),
  .rsp_count    (rsp.component_count),
  .rsp_depth    (rsp.stack_depth),
  .cfg_valid    (cfg.valid),
  .cfg_ready    (cfg.ready)
);
`default_nettype wire
